### design/image_sampler_bilinear_ignore_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the image sampler core
// Shared concurrent assertion forms, clocked on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef IMAGE_SAMPLER_BILINEAR_IGNORE_CORE_DEFINES_SVH
`define IMAGE_SAMPLER_BILINEAR_IGNORE_CORE_DEFINES_SVH

// Checked only outside reset.
`define ISBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ISBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/isbi_pkg.sv
// ----------------------------------------------------------------------------
// isbi_pkg
// Types and codes shared by the image sampler core.
// ----------------------------------------------------------------------------
package isbi_pkg;

  typedef struct packed {
    logic               command;
    logic        [15:0] col_pos;
    logic        [15:0] row_pos;
    logic signed [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               is_nodata;
  } out_item_t;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_READ = 8'b0000_0100,
    S_RULE = 8'b0000_1000,
    S_MULH = 8'b0001_0000,
    S_MULV = 8'b0010_0000,
    S_RND  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

### design/isbi_ram.sv
// ----------------------------------------------------------------------------
// isbi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module isbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### design/image_sampler_bilinear_ignore_core.sv
// ----------------------------------------------------------------------------
// image_sampler_bilinear_ignore_core
// Single-band image store with nearest and bilinear sampling and no-data
// handling of neighbours.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    isbi_pkg::in_item_t
//  out      output     out_valid/out_ready  isbi_pkg::out_item_t
//  cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// A write returns to idle after the prep step; an out-of-bounds sample goes
// straight to output. A bilinear sample reads the four neighbours, one per
// cycle, from the single-port pixel RAM, then runs the neighbour rules, two
// multiply stages and rounding. A new input is taken only in idle.
// A waiting result stalls the sequencer only when the next result is ready.
// Reset sets control and config to their defaults; pixel contents stay undefined until written.
// ----------------------------------------------------------------------------
`include "image_sampler_bilinear_ignore_core_defines.svh"

module image_sampler_bilinear_ignore_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  isbi_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output isbi_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [isbi_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [15:0]                        cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DW = 17;
  localparam int HW = FRAC_BITS + 18;
  localparam int SW = HW + FRAC_BITS + 2;
  localparam logic [15:0] HALF_FX = 16'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (2 * FRAC_BITS - 1);

  // config
  logic [8:0]         width_r, height_r;
  logic signed [15:0] nodata_r;
  logic               mode_r;

  // control
  isbi_pkg::state_t state_r, state_nxt;
  logic [2:0]       rd_cnt_r, rd_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic                  cmd_r;
  logic [15:0]           cpos_r, rpos_r;
  logic signed [15:0]    pix_r;
  logic [DW-1:0]         c1_r, c2_r, r1_r, r2_r;
  logic [FRAC_BITS-1:0]  p_r, q_r;
  logic                  oob_r;
  logic signed [15:0]    px_r [4];
  logic signed [HW-1:0]  top_r, bot_r;
  logic signed [SW-1:0]  sum_r;
  logic signed [15:0]    res_val_r;
  logic                  res_nd_r;
  isbi_pkg::out_item_t   out_data_r;

  // combinational
  logic [DW-1:0]         w_eff, h_eff, col, row, xc, yc, c2, r2;
  logic [15:0]           x, y;
  logic                  oob;
  logic [DW-1:0]         acol, arow;
  logic [AW-1:0]         ram_addr;
  logic                  ram_we;
  logic [15:0]           ram_rdata;
  logic signed [15:0]    a1, a2, a3, a4;
  logic                  rej;
  logic [FRAC_BITS:0]    ip, iq;
  logic signed [HW-1:0]  top, bot;
  logic signed [SW-1:0]  sum, rnd;
  logic                  out_free;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      nodata_r <= 16'sh8000;
      mode_r   <= isbi_pkg::MODE_NEAREST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        isbi_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[8:0];
        isbi_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[8:0];
        isbi_pkg::CFG_NODATA_VALUE: nodata_r <= cfg_wdata;
        isbi_pkg::CFG_SAMPLE_MODE:  mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- coordinate prep
  always_comb begin
    w_eff = (DW'(width_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_r);
    h_eff = (DW'(height_r) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_r);
    col   = DW'(cpos_r >> FRAC_BITS);
    row   = DW'(rpos_r >> FRAC_BITS);
    oob   = (col >= w_eff) || (row >= h_eff);
    // step back half a pixel, stop at zero
    x     = (cpos_r >= HALF_FX) ? cpos_r - HALF_FX : '0;
    y     = (rpos_r >= HALF_FX) ? rpos_r - HALF_FX : '0;
    xc    = DW'(x >> FRAC_BITS);
    yc    = DW'(y >> FRAC_BITS);
    c2    = (xc + DW'(1) < w_eff) ? xc + DW'(1) : w_eff - DW'(1);
    r2    = (yc + DW'(1) < h_eff) ? yc + DW'(1) : h_eff - DW'(1);
  end

  // ------------------------------------------------------------ pixel RAM
  always_comb begin
    acol = c1_r;
    arow = r1_r;
    if (state_r == isbi_pkg::S_PREP) begin
      acol = col;
      arow = row;
    end else begin
      unique case (rd_cnt_r[1:0])
        2'd0: begin acol = c1_r; arow = r1_r; end
        2'd1: begin acol = c2_r; arow = r1_r; end
        2'd2: begin acol = c1_r; arow = r2_r; end
        2'd3: begin acol = c2_r; arow = r2_r; end
        default: ;
      endcase
    end
    ram_addr = AW'(32'(arow) * 32'(MAX_WIDTH) + 32'(acol));
    ram_we   = (state_r == isbi_pkg::S_PREP) && (cmd_r == isbi_pkg::CMD_WRITE) && !oob;
  end

  isbi_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pix_r),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------- no-data rules
  always_comb begin
    a1  = px_r[0];
    a2  = px_r[1];
    a3  = px_r[2];
    a4  = px_r[3];
    rej = 1'b0;
    // p_r / q_r MSB set means the fraction is at least one half
    if (a1 == nodata_r) begin
      if (!p_r[FRAC_BITS-1]) rej = 1'b1;
      else a1 = a2;
    end
    if (a2 == nodata_r) begin
      if (p_r[FRAC_BITS-1]) rej = 1'b1;
      else a2 = a1;
    end
    if (a3 == nodata_r) begin
      if (!p_r[FRAC_BITS-1]) rej = 1'b1;
      else a3 = a4;
    end
    if (a4 == nodata_r) begin
      if (p_r[FRAC_BITS-1]) rej = 1'b1;
      else a4 = a3;
    end
    if (a1 == nodata_r) begin
      if (!q_r[FRAC_BITS-1]) begin
        rej = 1'b1;
      end else begin
        a1 = a3;
        a2 = a4;
      end
    end
    if (a3 == nodata_r) begin
      if (q_r[FRAC_BITS-1]) begin
        rej = 1'b1;
      end else begin
        a3 = a1;
        a4 = a2;
      end
    end
  end

  // ----------------------------------------------------------- arithmetic
  always_comb begin
    ip  = ONE_FX - {1'b0, p_r};
    iq  = ONE_FX - {1'b0, q_r};
    top = HW'($signed({1'b0, ip})) * HW'(px_r[0])
        + HW'($signed({1'b0, p_r})) * HW'(px_r[1]);
    bot = HW'($signed({1'b0, ip})) * HW'(px_r[2])
        + HW'($signed({1'b0, p_r})) * HW'(px_r[3]);
    sum = SW'($signed({1'b0, iq})) * SW'(top_r)
        + SW'($signed({1'b0, q_r})) * SW'(bot_r);
    rnd = sum_r + RND_HALF;
  end

  // ------------------------------------------------------------ sequencer
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      isbi_pkg::S_IDLE: begin
        if (in_valid) state_nxt = isbi_pkg::S_PREP;
      end
      isbi_pkg::S_PREP: begin
        rd_cnt_nxt = '0;
        if (cmd_r == isbi_pkg::CMD_WRITE) state_nxt = isbi_pkg::S_IDLE;
        else if (oob) state_nxt = isbi_pkg::S_OUT;
        else state_nxt = isbi_pkg::S_READ;
      end
      isbi_pkg::S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (mode_r == isbi_pkg::MODE_NEAREST && rd_cnt_r == 3'd1) begin
          state_nxt = isbi_pkg::S_OUT;
        end else if (rd_cnt_r == 3'd4) begin
          state_nxt = isbi_pkg::S_RULE;
        end
      end
      isbi_pkg::S_RULE: state_nxt = rej ? isbi_pkg::S_OUT : isbi_pkg::S_MULH;
      isbi_pkg::S_MULH: state_nxt = isbi_pkg::S_MULV;
      isbi_pkg::S_MULV: state_nxt = isbi_pkg::S_RND;
      isbi_pkg::S_RND:  state_nxt = isbi_pkg::S_OUT;
      isbi_pkg::S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = isbi_pkg::S_IDLE;
        end
      end
      default: state_nxt = isbi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isbi_pkg::S_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      isbi_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_r  <= in_data.command;
          cpos_r <= in_data.col_pos;
          rpos_r <= in_data.row_pos;
          pix_r  <= in_data.pixel_in;
        end
      end
      isbi_pkg::S_PREP: begin
        oob_r    <= oob;
        res_val_r <= nodata_r;
        res_nd_r <= 1'b1;
        c2_r     <= c2;
        r2_r     <= r2;
        p_r      <= x[FRAC_BITS-1:0];
        q_r      <= y[FRAC_BITS-1:0];
        if (mode_r == isbi_pkg::MODE_NEAREST) begin
          c1_r <= col;
          r1_r <= row;
        end else begin
          c1_r <= xc;
          r1_r <= yc;
        end
      end
      isbi_pkg::S_READ: begin
        if (rd_cnt_r != 3'd0) begin
          px_r[2'(rd_cnt_r - 3'd1)] <= ram_rdata;
        end
        if (mode_r == isbi_pkg::MODE_NEAREST) begin
          res_val_r <= ram_rdata;
          res_nd_r  <= 1'b0;
        end
      end
      isbi_pkg::S_RULE: begin
        px_r[0] <= a1;
        px_r[1] <= a2;
        px_r[2] <= a3;
        px_r[3] <= a4;
      end
      isbi_pkg::S_MULH: begin
        top_r <= top;
        bot_r <= bot;
      end
      isbi_pkg::S_MULV: sum_r <= sum;
      isbi_pkg::S_RND: begin
        res_val_r <= 16'(rnd >>> (2 * FRAC_BITS));
        res_nd_r  <= 1'b0;
      end
      isbi_pkg::S_OUT: begin
        if (out_free) begin
          out_data_r.sample_value <= res_val_r;
          out_data_r.is_nodata    <= res_nd_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == isbi_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ----------------------------------------------------------- assertions
  `ISBI_ASSERT(a_accept_to_prep, in_valid && in_ready |=> state_r == isbi_pkg::S_PREP, "transfer did not start prep")
  `ISBI_ASSERT(a_out_from_seq, $rose(out_valid_r) |-> $past(state_r == isbi_pkg::S_OUT), "result appeared outside output step")
  `ISBI_ASSERT(a_out_is_sample, state_r == isbi_pkg::S_OUT |-> cmd_r == isbi_pkg::CMD_SAMPLE, "write item produced a result")
  `ISBI_ASSERT(a_read_in_bounds, state_r == isbi_pkg::S_READ |-> !oob_r, "pixel read for out-of-bounds sample")
  `ISBI_ASSERT(a_nearest_valid, state_r == isbi_pkg::S_OUT && mode_r == isbi_pkg::MODE_NEAREST && !oob_r |-> !res_nd_r, "nearest result flagged no-data")

endmodule

### tb/image_sampler_bilinear_ignore_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_sampler_bilinear_ignore_core_test
// Drives pixel writes and sample requests through the valid/ready input
// channel and checks each sample result against its table value or a behavioral
// predictor of the image store, the nearest and bilinear paths and the no-data rules.
// A short directed table comes first, then random traffic over a series of
// register settings, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module image_sampler_bilinear_ignore_core_test;

  localparam int GRID            = 256;      // store row pitch and size limit
  localparam int FRAC            = 8;
  localparam int HALF_STEP       = 1 << (FRAC - 1);
  localparam int ONE_STEP        = 1 << FRAC;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int CYCLE_CAP       = 600000;

  typedef struct {
    bit                             is_reg;
    logic [isbi_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                    wdata;
    isbi_pkg::in_item_t             item;
    bit                             typed;
    isbi_pkg::out_item_t            want;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  isbi_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  isbi_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [isbi_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]                    cfg_wdata;

  // Shadow of the register file and the pixel store
  logic [8:0]         img_w;
  logic [8:0]         img_h;
  logic signed [15:0] nd_val;
  logic               mode_sel;
  logic signed [15:0] image_mem [0:GRID*GRID-1];
  bit                 written_map [0:GRID*GRID-1];

  isbi_pkg::out_item_t pending_samples[$];
  step_t               directed_steps[$];
  int                  fault_count   = 0;
  int                  cycle_count   = 0;
  int                  sent_count    = 0;
  int                  checked_count = 0;
  int                  setting_count = 0;
  bit                  calm          = 1'b0;

  image_sampler_bilinear_ignore_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int span(input logic [8:0] reg_val);
    return (reg_val > GRID) ? GRID : int'(reg_val);
  endfunction

  function automatic bit in_image(input logic [15:0] cpos, input logic [15:0] rpos);
    return (int'(cpos[15:8]) < span(img_w)) && (int'(rpos[15:8]) < span(img_h));
  endfunction

  // Back off half a pixel, clamp the far neighbours to the last column and row
  function automatic void locate(input logic [15:0] cpos, input logic [15:0] rpos,
                                 output int c1, output int c2, output int r1,
                                 output int r2, output int p, output int q);
    int x;
    int y;
    x  = (cpos >= HALF_STEP) ? int'(cpos) - HALF_STEP : 0;
    y  = (rpos >= HALF_STEP) ? int'(rpos) - HALF_STEP : 0;
    c1 = x >> FRAC;
    r1 = y >> FRAC;
    c2 = (c1 + 1 < span(img_w)) ? c1 + 1 : span(img_w) - 1;
    r2 = (r1 + 1 < span(img_h)) ? r1 + 1 : span(img_h) - 1;
    p  = x & (ONE_STEP - 1);
    q  = y & (ONE_STEP - 1);
  endfunction

  function automatic isbi_pkg::out_item_t sample_image(input logic [15:0] cpos,
                                                       input logic [15:0] rpos);
    int                  c1, c2, r1, r2, p, q;
    logic signed [15:0]  a1, a2, a3, a4;
    longint              sum;
    isbi_pkg::out_item_t res;
    res.sample_value = nd_val;
    res.is_nodata    = 1'b1;
    if (!in_image(cpos, rpos)) return res;
    if (mode_sel == isbi_pkg::MODE_NEAREST) begin
      res.sample_value = image_mem[int'(rpos[15:8]) * GRID + int'(cpos[15:8])];
      res.is_nodata    = 1'b0;
      return res;
    end
    locate(cpos, rpos, c1, c2, r1, r2, p, q);
    a1 = image_mem[r1 * GRID + c1];
    a2 = image_mem[r1 * GRID + c2];
    a3 = image_mem[r2 * GRID + c1];
    a4 = image_mem[r2 * GRID + c2];
    if (a1 == nd_val) begin
      if (p < HALF_STEP) return res;
      a1 = a2;
    end
    if (a2 == nd_val) begin
      if (p >= HALF_STEP) return res;
      a2 = a1;
    end
    if (a3 == nd_val) begin
      if (p < HALF_STEP) return res;
      a3 = a4;
    end
    if (a4 == nd_val) begin
      if (p >= HALF_STEP) return res;
      a4 = a3;
    end
    if (a1 == nd_val) begin
      if (q < HALF_STEP) return res;
      a1 = a3;
      a2 = a4;
    end
    if (a3 == nd_val) begin
      if (q >= HALF_STEP) return res;
      a3 = a1;
      a4 = a2;
    end
    sum = longint'(ONE_STEP - q) * (longint'(ONE_STEP - p) * longint'(a1) +
                                    longint'(p) * longint'(a2)) +
          longint'(q) * (longint'(ONE_STEP - p) * longint'(a3) +
                         longint'(p) * longint'(a4));
    // round half up, then drop the 2*FRAC fraction bits
    sum = (sum + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
    res.sample_value = sum[15:0];
    res.is_nodata    = 1'b0;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Lean on the no-data value and the range ends
  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0, 1, 2: return nd_val;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_frac();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'(HALF_STEP - 1);
      2:       return 8'(HALF_STEP);
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic step_t reg_step(input logic [isbi_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [15:0] wdata);
    step_t s;
    s        = '{default: '0};
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.wdata  = wdata;
    return s;
  endfunction

  function automatic step_t item_step(input logic cmd, input logic [15:0] cpos,
                                      input logic [15:0] rpos, input logic [15:0] pix,
                                      input bit typed, input logic [15:0] want_val,
                                      input logic want_nd);
    step_t s;
    s       = '{default: '0};
    s.item  = '{command: cmd, col_pos: cpos, row_pos: rpos, pixel_in: pix};
    s.typed = typed;
    s.want  = '{sample_value: want_val, is_nodata: want_nd};
    return s;
  endfunction

  // Hold the item until its transfer, then update the shadow store or
  // queue the expected sample
  task automatic send_item(input isbi_pkg::in_item_t it, input bit typed,
                           input isbi_pkg::out_item_t want);
    int gap;
    int addr;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (it.command == isbi_pkg::CMD_WRITE) begin
      if (in_image(it.col_pos, it.row_pos)) begin
        addr = int'(it.row_pos[15:8]) * GRID + int'(it.col_pos[15:8]);
        image_mem[addr]   = it.pixel_in;
        written_map[addr] = 1'b1;
      end
    end else begin
      pending_samples.push_back(typed ? want : sample_image(it.col_pos, it.row_pos));
    end
  endtask

  // Write every pixel a sample will read that has no value yet; with
  // refresh, also overwrite some of the others to stir up the no-data rules
  task automatic prime_reads(input logic [15:0] cpos, input logic [15:0] rpos,
                             input bit refresh);
    int                  c1, c2, r1, r2, p, q, n, addr;
    int                  cols[4];
    int                  rows[4];
    isbi_pkg::in_item_t  wr;
    isbi_pkg::out_item_t none;
    none = '0;
    if (!in_image(cpos, rpos)) return;
    if (mode_sel == isbi_pkg::MODE_NEAREST) begin
      n       = 1;
      cols[0] = int'(cpos[15:8]);
      rows[0] = int'(rpos[15:8]);
    end else begin
      locate(cpos, rpos, c1, c2, r1, r2, p, q);
      n    = 4;
      cols = '{c1, c2, c1, c2};
      rows = '{r1, r1, r2, r2};
    end
    for (int i = 0; i < n; i++) begin
      addr = rows[i] * GRID + cols[i];
      if (!written_map[addr] || (refresh && $urandom_range(0, 1) == 1)) begin
        wr.command  = isbi_pkg::CMD_WRITE;
        wr.col_pos  = {8'(cols[i]), 8'($urandom)};
        wr.row_pos  = {8'(rows[i]), 8'($urandom)};
        wr.pixel_in = pick_pixel();
        send_item(wr, 1'b0, none);
      end
    end
  endtask

  task automatic cfg_write(input logic [isbi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] wdata);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    case (idx)
      isbi_pkg::CFG_IMAGE_WIDTH:  img_w    = wdata[8:0];
      isbi_pkg::CFG_IMAGE_HEIGHT: img_h    = wdata[8:0];
      isbi_pkg::CFG_NODATA_VALUE: nd_val   = wdata;
      isbi_pkg::CFG_SAMPLE_MODE:  mode_sel = wdata[0];
      default: ;
    endcase
  endtask

  // Drop valid, wait for every sample, then let a trailing write finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_out_ready
    static int stall_left = 0;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready  <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    isbi_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result transfer: sample_value %0d is_nodata %0b",
               out_data.sample_value, out_data.is_nodata);
        fault_count++;
      end else begin
        want = pending_samples.pop_front();
        checked_count++;
        if (out_data.sample_value !== want.sample_value) begin
          $error("sample_value: expected %0d, got %0d",
                 want.sample_value, out_data.sample_value);
          fault_count++;
        end
        if (out_data.is_nodata !== want.is_nodata) begin
          $error("is_nodata: expected %0b, got %0b", want.is_nodata, out_data.is_nodata);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("image_sampler_bilinear_ignore_core: mismatch");
      $finish;
    end
  end

  initial begin : run
    isbi_pkg::in_item_t  it;
    isbi_pkg::out_item_t none;
    logic [8:0]  w9, h9;
    logic [15:0] ndv;
    logic        mode_pick;
    int          pick, phase_end;
    bit          aim_inside;

    none      = '0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    img_w     = 9'd256;
    img_h     = 9'd256;
    nd_val    = 16'sh8000;
    mode_sel  = isbi_pkg::MODE_NEAREST;

    // Reset values: full size, most negative no-data, nearest
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0000, 16'h0000, 16'h7FFF,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 0,
                                       1, 16'h7FFF, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF, 16'h8000,
                                       0, 0, 0));
    // nearest hands back a stored no-data value unflagged
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 0,
                                       1, 16'h8000, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h12AB, 16'h3480, 16'd1234,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h12FF, 16'h3400, 0,
                                       1, 16'd1234, 0));
    directed_steps.push_back(reg_step(isbi_pkg::CFG_IMAGE_WIDTH, 16'd4));
    directed_steps.push_back(reg_step(isbi_pkg::CFG_IMAGE_HEIGHT, 16'd3));
    // writes just past the right and bottom edges are dropped
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0400, 16'h0000, 16'd5,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0000, 16'h0300, 16'd6,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0400, 16'h0000, 0,
                                       1, 16'h8000, 1));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0000, 16'h0300, 0,
                                       1, 16'h8000, 1));
    directed_steps.push_back(reg_step(isbi_pkg::CFG_NODATA_VALUE, 16'h7FFF));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0080, 16'h0080, 0,
                                       1, 16'h7FFF, 0));
    directed_steps.push_back(reg_step(isbi_pkg::CFG_SAMPLE_MODE,
                                      16'(isbi_pkg::MODE_BILINEAR)));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0100, 16'h0000, 16'd200,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0000, 16'h0100, -16'sd300,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0100, 16'h0100, 16'd400,
                                       0, 0, 0));
    // shift clamps at zero; top-left is no-data with a small fraction
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0040, 16'h0040, 0,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0000, 16'h0000, 16'd100,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0180, 16'h0180, 0,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h00C0, 16'h0140, 0,
                                       0, 0, 0));
    // last column and row: far neighbours clamp
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h03FF, 16'h02FF, 0,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_WRITE, 16'h0100, 16'h0000, 16'h7FFF,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0100, 16'h0080, 0,
                                       0, 0, 0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h00F0, 16'h0080, 0,
                                       0, 0, 0));
    directed_steps.push_back(reg_step(isbi_pkg::CFG_IMAGE_WIDTH, 16'd0));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 0,
                                       1, 16'h7FFF, 1));
    // width above the store size acts as the store size
    directed_steps.push_back(reg_step(isbi_pkg::CFG_IMAGE_WIDTH, 16'd300));
    directed_steps.push_back(item_step(isbi_pkg::CMD_SAMPLE, 16'hFF80, 16'h0080, 0,
                                       0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_reg) begin
        settle();
        cfg_write(directed_steps[i].idx, directed_steps[i].wdata);
        cfg_we <= 1'b0;
      end else begin
        if (directed_steps[i].item.command == isbi_pkg::CMD_SAMPLE)
          prime_reads(directed_steps[i].item.col_pos, directed_steps[i].item.row_pos, 1'b0);
        send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      ndv       = 16'($urandom);
      mode_pick = 1'($urandom);
      case (ph)
        0: begin
          w9 = 9'd1;   h9 = 9'd1;   ndv = 16'h8000; mode_pick = isbi_pkg::MODE_BILINEAR;
        end
        1: begin
          w9 = 9'd2;   h9 = 9'd2;   ndv = 16'h7FFF; mode_pick = isbi_pkg::MODE_BILINEAR;
        end
        2: begin
          w9 = 9'd256; h9 = 9'd256; ndv = 16'h0000; mode_pick = isbi_pkg::MODE_NEAREST;
        end
        3: begin w9 = 9'd511; h9 = 9'd5;   mode_pick = isbi_pkg::MODE_BILINEAR; end
        4: begin w9 = 9'd0;   h9 = 9'd7;   mode_pick = isbi_pkg::MODE_NEAREST;  end
        5: begin w9 = 9'd6;   h9 = 9'd0;   mode_pick = isbi_pkg::MODE_BILINEAR; end
        9: begin w9 = 9'd256; h9 = 9'd256; mode_pick = isbi_pkg::MODE_BILINEAR; end
        default: begin
          w9 = 9'($urandom_range(1, 12));
          h9 = 9'($urandom_range(1, 12));
        end
      endcase
      settle();
      // upper data bits above each register's width are don't-care
      cfg_write(isbi_pkg::CFG_IMAGE_WIDTH, {7'($urandom), w9});
      cfg_write(isbi_pkg::CFG_IMAGE_HEIGHT, {7'($urandom), h9});
      cfg_write(isbi_pkg::CFG_NODATA_VALUE, ndv);
      cfg_write(isbi_pkg::CFG_SAMPLE_MODE, {15'($urandom), mode_pick});
      cfg_we <= 1'b0;
      setting_count++;
      calm      = ($urandom_range(0, 3) == 0);
      // budget the phase by input transfers, priming writes included
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        pick       = $urandom_range(0, 9);
        aim_inside = (pick != 7) && (pick != 8) && span(img_w) > 0 && span(img_h) > 0;
        it.command  = (pick >= 8) ? isbi_pkg::CMD_WRITE : isbi_pkg::CMD_SAMPLE;
        it.pixel_in = pick_pixel();
        if (aim_inside) begin
          it.col_pos = {8'($urandom_range(0, span(img_w) - 1)), pick_frac()};
          it.row_pos = {8'($urandom_range(0, span(img_h) - 1)), pick_frac()};
        end else begin
          it.col_pos = 16'($urandom);
          it.row_pos = 16'($urandom);
        end
        if (it.command == isbi_pkg::CMD_SAMPLE) begin
          prime_reads(it.col_pos, it.row_pos, pick < 5);
        end
        send_item(it, 1'b0, none);
      end
    end

    settle();
    $display("%0d input transfers, %0d samples checked across %0d register settings",
             sent_count, checked_count, setting_count + 1);
    if (fault_count == 0) begin
      $display("image_sampler_bilinear_ignore_core: match");
    end else begin
      $display("image_sampler_bilinear_ignore_core: mismatch");
    end
    $finish;
  end

endmodule
